// File: design/fpsc_pkg.sv
// shared constants, types and polynomial coefficients of the sine / cosine unit
// no dependencies
package fpsc_pkg;

  localparam int FRAC_BITS = 32;
  localparam int NUM_STEPS = 6;
  localparam int LATENCY   = 39;

  localparam logic [63:0] ONE_Q         = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HALF_Q        = 64'h0000_0000_8000_0000;
  localparam logic [63:0] TWO_OVER_PI_Q = 64'h0000_0000_A2F9_836E;
  localparam logic [63:0] PI_OVER_2_Q   = 64'h0000_0001_921F_B544;

  // horner coefficients, innermost first; the last cosine step is the halving
  localparam logic [63:0] SIN_RECIP [NUM_STEPS] = '{
    ONE_Q / 64'd156, ONE_Q / 64'd110, ONE_Q / 64'd72,
    ONE_Q / 64'd42,  ONE_Q / 64'd20,  ONE_Q / 64'd6
  };
  localparam logic [63:0] COS_RECIP [NUM_STEPS] = '{
    ONE_Q / 64'd132, ONE_Q / 64'd90, ONE_Q / 64'd56,
    ONE_Q / 64'd30,  ONE_Q / 64'd12, ONE_Q / 64'd2
  };

  typedef struct packed {
    logic        func;
    logic        neg;
    logic [63:0] r;
    logic [63:0] r2;
  } side_t;

endpackage

// File: design/fpsc_qmul.sv
// two-stage pipelined q32.32 multiply, result modulo 2^64
// depends on nothing
module fpsc_qmul (
  input  logic        clk,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic [63:0] p
);

  logic signed [32:0] xh, yh, xl, yl;
  logic signed [65:0] hl_full, lh_full;
  logic        [63:0] ll_full;
  logic        [31:0] hh;
  logic        [63:0] hl, lh;
  logic        [31:0] llh;

  assign xh = {x[63], x[63:32]};
  assign yh = {y[63], y[63:32]};
  assign xl = {1'b0, x[31:0]};
  assign yl = {1'b0, y[31:0]};
  assign hl_full = xh * yl;
  assign lh_full = xl * yh;
  assign ll_full = {32'b0, x[31:0]} * {32'b0, y[31:0]};

  always_ff @(posedge clk) begin
    hh  <= 32'(x[63:32] * y[63:32]);
    hl  <= hl_full[63:0];
    lh  <= lh_full[63:0];
    llh <= ll_full[63:32];
  end

  always_ff @(posedge clk) begin
    p <= {hh, 32'b0} + hl + lh + {32'b0, llh};
  end

endmodule

// File: design/fpsc_reduce.sv
// range reduction: quadrant, reduced angle r and its square
// depends on fpsc_pkg and fpsc_qmul
module fpsc_reduce (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           op,
  input  logic [63:0]    angle,
  output logic           out_valid,
  output fpsc_pkg::side_t out_side,
  output logic [63:0]    out_v
);
  import fpsc_pkg::*;

  logic [7:0]  valid;
  logic [63:0] a_d [5];
  logic        op_d [3];
  logic [63:0] t_prod, t, k_prod;
  logic [1:0]  kq, kq_d, quad;
  logic [1:0]  quad_d [2];
  logic [63:0] r;
  logic [63:0] r_d [2];
  logic [63:0] r2;

  fpsc_qmul u_mul_k (.clk(clk), .x(angle), .y(TWO_OVER_PI_Q), .p(t_prod));
  fpsc_qmul u_mul_r (.clk(clk), .x({t[63:32], 32'b0}), .y(PI_OVER_2_Q), .p(k_prod));
  fpsc_qmul u_mul_sq (.clk(clk), .x(r), .y(r), .p(r2));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    a_d[0]    <= angle;
    op_d[0]   <= op;
    for (int i = 1; i < 5; i++) a_d[i] <= a_d[i-1];
    for (int i = 1; i < 3; i++) op_d[i] <= op_d[i-1];
    t         <= t_prod + HALF_Q;
    kq        <= t[33:32] + {1'b0, op_d[2]};
    kq_d      <= kq;
    quad      <= kq_d;
    r         <= a_d[4] - k_prod;
    r_d[0]    <= r;
    r_d[1]    <= r_d[0];
    quad_d[0] <= quad;
    quad_d[1] <= quad_d[0];
  end

  assign out_valid     = valid[7];
  assign out_side.func = quad_d[1][0];
  assign out_side.neg  = quad_d[1][1];
  assign out_side.r    = r_d[1];
  assign out_side.r2   = r2;
  assign out_v         = quad_d[1][0] ? ONE_Q : r_d[1];

endmodule

// File: design/fpsc_step.sv
// one horner step: v' = c - (r2 * v) * recip, five register stages
// depends on fpsc_pkg and fpsc_qmul
module fpsc_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  fpsc_pkg::side_t in_side,
  input  logic [63:0]     in_v,
  input  logic [63:0]     rcp_sin,
  input  logic [63:0]     rcp_cos,
  output logic            out_valid,
  output fpsc_pkg::side_t out_side,
  output logic [63:0]     out_v
);
  import fpsc_pkg::*;

  logic [4:0]  valid;
  side_t       side_d [5];
  logic [63:0] prod_a, prod_b, c;

  fpsc_qmul u_mul_a (.clk(clk), .x(in_side.r2), .y(in_v), .p(prod_a));
  fpsc_qmul u_mul_b (
    .clk(clk), .x(prod_a), .y(side_d[1].func ? rcp_cos : rcp_sin), .p(prod_b)
  );

  assign c = side_d[3].func ? ONE_Q : side_d[3].r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_d[0] <= in_side;
    for (int i = 1; i < 5; i++) side_d[i] <= side_d[i-1];
    out_v <= c - prod_b;
  end

  assign out_valid = valid[4];
  assign out_side  = side_d[4];

endmodule

// File: design/fixed_point_sin_cos_top.sv
// top level of the q32.32 sine / cosine unit
// depends on fpsc_pkg, fpsc_reduce and fpsc_step
//
// command channel: drive op (0 sine, 1 cosine) and angle (signed q32.32,
// radians) with start high; a beat is taken at each rising edge with start
// high and busy low. busy is high only while rst is asserted, so a new beat
// may be issued in every cycle.
// result channel: result (signed q32.32) is shown for one cycle with done
// high once the beat has passed reduction, six horner steps and the output
// register; beats leave in order.
// throughput is one beat per cycle: a fully pipelined chain of fifteen
// two-stage 32.32 multipliers (reduction, squaring, six horner steps of two
// multiplies each) plus subtract and sign stages.
// reset clears every valid bit; beats in flight are dropped and done stays
// low until new beats have passed through. the receiver cannot stall, so
// nothing in the pipeline ever waits.
module fixed_point_sin_cos_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        op,
  input  logic [63:0] angle,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);
  import fpsc_pkg::*;

  logic        valid [NUM_STEPS+1];
  side_t       side  [NUM_STEPS+1];
  logic [63:0] v     [NUM_STEPS+1];

  assign busy = rst;

  fpsc_reduce u_reduce (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .op(op), .angle(angle),
    .out_valid(valid[0]), .out_side(side[0]), .out_v(v[0])
  );

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
    fpsc_step u_step (
      .clk(clk), .rst(rst),
      .in_valid(valid[g]), .in_side(side[g]), .in_v(v[g]),
      .rcp_sin(SIN_RECIP[g]), .rcp_cos(COS_RECIP[g]),
      .out_valid(valid[g+1]), .out_side(side[g+1]), .out_v(v[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    result <= side[NUM_STEPS].neg ? 64'd0 - v[NUM_STEPS] : v[NUM_STEPS];
  end

endmodule

// File: design/fpsc_checker.sv
// port-level checks of the sine / cosine unit, bound to the top level
// depends on fpsc_pkg and fixed_point_sin_cos_top
module fpsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        op,
  input logic [63:0] angle,
  input logic        busy,
  input logic        done,
  input logic [63:0] result
);
  import fpsc_pkg::*;

  a_done_has_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result beat without a matching command beat");

  a_beat_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("command beat produced no result beat");

  a_sin_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !op && angle == 64'd0) |-> ##LATENCY (result == 64'd0))
    else $error("sine of zero is not zero");

  a_cos_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op && angle == 64'd0) |-> ##LATENCY (result == ONE_Q))
    else $error("cosine of zero is not one");

endmodule

bind fixed_point_sin_cos_top fpsc_checker u_fpsc_checker (
  .clk(clk), .rst(rst), .start(start), .op(op), .angle(angle),
  .busy(busy), .done(done), .result(result)
);

// File: dv/fixed_point_sin_cos_top_tb.sv
// testbench for the q32.32 sine / cosine unit: directed and random angles
// depends on fpsc_pkg and fixed_point_sin_cos_top
`timescale 1ns / 100ps

module fixed_point_sin_cos_top_tb;
  import fpsc_pkg::*;

  localparam logic OP_SIN = 1'b0;
  localparam logic OP_COS = 1'b1;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic        op;
    logic [63:0] angle;
  } angle_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        op = 1'b0;
  logic [63:0] angle = '0;
  logic        busy;
  logic        done;
  logic [63:0] result;

  angle_beat_t pending_angles[$];
  logic [63:0] expected_values[$];
  int          errors = 0;
  int          sent = 0;
  int          received = 0;
  int          idle_cycles = 0;
  int          gap = 0;
  bit          stim_done = 0;

  fixed_point_sin_cos_top dut (
    .clk(clk), .rst(rst), .start(start), .op(op), .angle(angle),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] q_mul(logic [63:0] x, logic [63:0] y);
    logic [63:0] xh, yh, xl, yl;
    xh = {{32{x[63]}}, x[63:32]};
    yh = {{32{y[63]}}, y[63:32]};
    xl = {32'b0, x[31:0]};
    yl = {32'b0, y[31:0]};
    return ((xh * yh) << 32) + xh * yl + xl * yh + ((xl * yl) >> 32);
  endfunction

  function automatic logic [63:0] sin_cos_of(logic f, logic [63:0] a);
    logic [63:0] t, r, r2, v, p;
    logic [1:0]  quad;
    int          sdiv[6] = '{156, 110, 72, 42, 20, 6};
    int          cdiv[5] = '{132, 90, 56, 30, 12};
    t = q_mul(a, 64'h0000_0000_A2F9_836E) + 64'h0000_0000_8000_0000;
    r = a - q_mul({t[63:32], 32'b0}, 64'h0000_0001_921F_B544);
    quad = t[33:32] + {1'b0, f};
    r2 = q_mul(r, r);
    if (quad[0]) begin
      v = 64'h1_0000_0000;
      for (int i = 0; i < 5; i++)
        v = 64'h1_0000_0000 - q_mul(q_mul(r2, v), 64'h1_0000_0000 / cdiv[i]);
      p = q_mul(r2, v);
      p = {p[63], p[63:1]};
      v = 64'h1_0000_0000 - p;
    end else begin
      v = r;
      for (int i = 0; i < 6; i++)
        v = r - q_mul(q_mul(r2, v), 64'h1_0000_0000 / sdiv[i]);
    end
    if (quad[1]) v = 64'd0 - v;
    return v;
  endfunction

  function automatic logic [63:0] rand_angle();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: a = {{32{a[63]}}, a[31:0]} >>> $urandom_range(0, 30);
      1: a = {{29{a[63]}}, a[34:0]};
      2: a = $signed(a) >>> $urandom_range(0, 60);
      default: ;
    endcase
    return a;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      sent <= sent + 1;
      expected_values.push_back(sin_cos_of(op, angle));
      if (pending_angles.size() > 0 && gap == 0) begin
        op <= pending_angles[0].op;
        angle <= pending_angles[0].angle;
        void'(pending_angles.pop_front());
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
      end else begin
        start <= 1'b0;
        if (gap > 0) gap = gap - 1;
      end
    end else if (!start && pending_angles.size() > 0) begin
      if (gap > 0) begin
        gap = gap - 1;
      end else begin
        op <= pending_angles[0].op;
        angle <= pending_angles[0].angle;
        start <= 1'b1;
        void'(pending_angles.pop_front());
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        if (result !== expected_values[0]) begin
          $display("%0t: result mismatch expected %h actual %h", $time,
                   expected_values[0], result);
          errors++;
        end
        void'(expected_values.pop_front());
      end
      received++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
      $display("%0t: watchdog expired", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] edge_angles[14];
    angle_beat_t b;
    edge_angles = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0,
                    64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0001_921F_B544,
                    64'hFFFF_FFFE_6DE0_4ABC, 64'h0000_0000_C90F_DAA2,
                    64'h0000_0000_C90F_DAA3, 64'h0000_0003_243F_6A88,
                    64'h0000_0001_0000_0000, 64'h0000_7FFF_0000_0000,
                    64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA};
    foreach (edge_angles[i]) begin
      b.op = OP_SIN;
      b.angle = edge_angles[i];
      pending_angles.push_back(b);
      if (i < 10) begin
        b.op = OP_COS;
        pending_angles.push_back(b);
      end
    end
    for (int i = 0; i < 500; i++) begin
      b.op = $urandom_range(0, 1) ? OP_COS : OP_SIN;
      b.angle = rand_angle();
      pending_angles.push_back(b);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_angles.size() == 0 && !start);
    wait (expected_values.size() == 0);
    stim_done = 1;
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d sine and cosine angles, %0d results checked",
             sent, received);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fpsc_pkg.sv
design/fpsc_qmul.sv
design/fpsc_reduce.sv
design/fpsc_step.sv
design/fixed_point_sin_cos_top.sv
design/fpsc_checker.sv
dv/fixed_point_sin_cos_top_tb.sv
